// File: sv/mcdma_pkg.sv
// shared types and constants for the multi-channel dma controller
`timescale 1ns / 1ps
package mcdma_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_TRIG  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] SEL_SRC   = 3'd0;
  localparam logic [2:0] SEL_DST   = 3'd1;
  localparam logic [2:0] SEL_TOTAL = 3'd2;
  localparam logic [2:0] SEL_WORDS = 3'd3;
  localparam logic [2:0] SEL_FILL  = 3'd4;
  localparam logic [2:0] SEL_CTRL  = 3'd5;

  localparam logic [1:0] STEP_INC   = 2'd0;
  localparam logic [1:0] STEP_DEC   = 2'd1;
  localparam logic [1:0] STEP_RSVD  = 2'd3;

  localparam logic [31:0] ADDR_MASK  = 32'hFFFF_FFFC;
  localparam logic [31:0] TOTAL_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] WORDS_MASK = 32'h00FF_FFFF;
  localparam logic [31:0] CTRL_MASK  = 32'hFF0F_FFFF;
  localparam logic [31:0] FILL_BASE  = 32'h1000_2018;
  localparam logic [31:0] FILL_PITCH = 32'h0000_001C;
  localparam logic [7:0]  MODE_MASK  = 8'h9F;
  localparam logic [7:0]  MODE_EN    = 8'h80;
  localparam logic [24:0] BLOCK_MAX  = 25'h100_0000;

  localparam int IN_W  = 80;
  localparam int OUT_W = 112;

  typedef struct packed {
    logic [3:0]  trigger_mode;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [2:0]  reg_select;
    logic [2:0]  channel;
    logic [1:0]  func;
  } item_t;

  typedef struct packed {
    logic [7:0]  pending_mask;
    logic        block_done;
    logic        irq_raise;
    logic [31:0] fill_value;
    logic        is_fill;
    logic [31:0] dst_address;
    logic [31:0] src_address;
    logic [2:0]  xfer_channel;
    logic        xfer_valid;
  } result_t;

  function automatic logic [31:0] step_of(input logic [1:0] code);
    case (code)
      STEP_INC: step_of = 32'd4;
      STEP_DEC: step_of = 32'hFFFF_FFFC;
      default:  step_of = 32'd0;
    endcase
  endfunction

endpackage

// File: sv/mcdma_front.sv
// input stage and item queue between stream input and channel engine
`timescale 1ns / 1ps
module mcdma_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mcdma_pkg::IN_W-1:0]  in_tdata,
  output logic                        q_valid,
  input  logic                        q_ready,
  output mcdma_pkg::item_t            q_item
);
  import mcdma_pkg::*;

  item_t      mem_r [2];
  logic [1:0] wp_r, rp_r;
  logic [1:0] cnt;
  logic       push, pop;

  assign cnt       = wp_r - rp_r;
  assign in_tready = (cnt != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rp_r[0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r[0]] <= item_t'(in_tdata[75:0]);
  end
endmodule

// File: sv/mcdma_engine.sv
// channel register file, scheduler and word copy sequencer
`timescale 1ns / 1ps
module mcdma_engine #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  mcdma_pkg::item_t     q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [111:0]         out_tdata
);
  import mcdma_pkg::*;

  logic [31:0] src_r [8];
  logic [31:0] dst_r [8];
  logic [27:0] tot_r [8];
  logic [23:0] wc_r  [8];
  logic [31:0] fill_r[8];
  logic [31:0] ctl_r [8];
  logic [31:0] csrc_r[8];
  logic [31:0] cdst_r[8];
  logic [7:0]  pend_r;
  logic        act_r;
  logic [24:0] rem_r;
  logic [2:0]  bch_r;
  logic [31:0] bctl_r;
  logic        ov_r;
  result_t     res_r;

  logic        go;
  logic [7:0]  chmask;
  logic        fnd;
  logic [2:0]  sch;
  logic [7:0]  drop;

  genvar g;
  for (g = 0; g < 8; g++) begin : g_mask
    assign chmask[g] = (g < NUM_CHANNELS);
  end

  assign q_ready    = !ov_r || out_tready;
  assign go         = q_valid && q_ready;
  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'(res_r);

  // scan pending channels upward, dropping reserved dest step
  always_comb begin
    fnd  = 1'b0;
    sch  = '0;
    drop = '0;
    for (int i = 0; i < 8; i++) begin
      if (!fnd && pend_r[i]) begin
        if (ctl_r[i][11:10] == STEP_RSVD) begin
          drop[i] = 1'b1;
        end else begin
          fnd = 1'b1;
          sch = 3'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        src_r[i] <= '0; dst_r[i] <= '0; tot_r[i] <= '0; wc_r[i] <= '0;
        fill_r[i] <= '0; ctl_r[i] <= '0; csrc_r[i] <= '0; cdst_r[i] <= '0;
      end
      pend_r <= '0;
      act_r  <= 1'b0;
      rem_r  <= '0;
      bch_r  <= '0;
      bctl_r <= '0;
      ov_r   <= 1'b0;
      res_r  <= '0;
    end else begin
      if (!go && out_tready) ov_r <= 1'b0;
      if (go) begin
        automatic logic [7:0]  p = pend_r;
        automatic result_t     r = '0;
        automatic logic [2:0]  c = q_item.channel;
        automatic logic [31:0] m = q_item.write_mask;
        automatic logic [31:0] d = q_item.write_data;
        automatic logic [31:0] nc;
        automatic logic [2:0]  ch;
        automatic logic [31:0] bc;
        automatic logic [31:0] cs;
        automatic logic [24:0] rm;
        automatic logic [27:0] tn;
        automatic logic        dn, iq, ok;
        ok = 1'b1;
        case (q_item.func)
          FUNC_WRITE: begin
            if (chmask[c]) begin
              case (q_item.reg_select)
                SEL_SRC:   src_r[c] <= (src_r[c] & ~(m & ADDR_MASK)) | (d & m & ADDR_MASK);
                SEL_DST:   dst_r[c] <= (dst_r[c] & ~(m & ADDR_MASK)) | (d & m & ADDR_MASK);
                SEL_TOTAL: tot_r[c] <= 28'((({4'd0, tot_r[c]}) & ~(m & TOTAL_MASK))
                                           | (d & m & TOTAL_MASK));
                SEL_WORDS: wc_r[c] <= 24'((({8'd0, wc_r[c]}) & ~(m & WORDS_MASK))
                                          | (d & m & WORDS_MASK));
                SEL_FILL:  fill_r[c] <= (fill_r[c] & ~m) | (d & m);
                SEL_CTRL: begin
                  nc = (ctl_r[c] & ~(m & CTRL_MASK)) | (d & m & CTRL_MASK);
                  ctl_r[c] <= nc;
                  if (!ctl_r[c][31] && nc[31]) begin
                    csrc_r[c] <= src_r[c];
                    cdst_r[c] <= dst_r[c];
                    if (nc[28]) p[c] = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
          FUNC_TRIG: begin
            for (int i = 0; i < 8; i++)
              if (chmask[i] && ((ctl_r[i][31:24] & MODE_MASK) ==
                                (MODE_EN | {4'd0, q_item.trigger_mode})))
                p[i] = 1'b1;
          end
          FUNC_TICK: begin
            ch = bch_r; bc = bctl_r; rm = rem_r; cs = csrc_r[bch_r];
            if (!act_r) begin
              p = p & ~drop;
              ok = fnd;
              ch = sch; bc = ctl_r[sch]; cs = csrc_r[sch];
              if (bc[14:13] == STEP_RSVD)
                cs = FILL_BASE + 32'(sch) * FILL_PITCH;
              rm = (wc_r[sch] != '0) ? {1'b0, wc_r[sch]} : BLOCK_MAX;
            end
            if (ok) begin
              r.xfer_valid = 1'b1;
              r.xfer_channel = ch;
              r.src_address = cs;
              r.dst_address = cdst_r[ch];
              r.is_fill = (bc[14:13] == STEP_RSVD);
              r.fill_value = fill_r[ch];
              rm = rm - 25'd1;
              dn = 1'b0; iq = 1'b0;
              tn = tot_r[ch];
              nc = ctl_r[ch];
              if (bc[28] || bc[29]) begin
                if (rm == '0) begin
                  dn = 1'b1; iq = bc[30];
                  if (bc[28]) nc[31] = 1'b0;
                end
              end else begin
                tn = tn - 28'd1;
                tot_r[ch] <= tn;
                if (tn == '0) begin
                  dn = 1'b1; iq = bc[30]; nc[31] = 1'b0;
                end else if (rm == '0) dn = 1'b1;
              end
              ctl_r[ch] <= nc;
              csrc_r[ch] <= (dn && bc[15]) ? src_r[ch] : cs + step_of(bc[14:13]);
              cdst_r[ch] <= (dn && bc[12]) ? dst_r[ch] : cdst_r[ch] + step_of(bc[11:10]);
              if (dn) begin
                p[ch] = 1'b0;
                act_r <= 1'b0;
                rem_r <= '0;
              end else begin
                act_r <= 1'b1;
                rem_r <= rm;
              end
              bch_r <= ch; bctl_r <= bc;
              r.irq_raise = iq;
              r.block_done = dn;
            end
          end
          default: ;
        endcase
        r.pending_mask = p;
        pend_r <= p;
        res_r  <= r;
        ov_r   <= 1'b1;
      end
    end
  end
endmodule

// File: sv/multi_channel_dma_controller.sv
// top level of the eight-channel word dma controller
//  channel | beat content                                  | direction
//  in_     | func, channel, reg_select, mask, data, trigger| slave
//  out_    | xfer_valid .. pending_mask, one per input beat| master
// one input beat is handled per cycle by the channel engine while the output does not stall
// a two-entry queue sits between the input port and the engine
// an accepted beat is held in a queue entry, then its result in the result register
// engine stalls while the result register is full and out_tready is low
// synchronous active-low reset clears all channel state
`timescale 1ns / 1ps
module multi_channel_dma_controller #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // func, channel, reg_select, write_mask, write_data, trigger_mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // xfer_valid, xfer_channel, src_address, dst_address,
                                   // is_fill, fill_value, irq_raise, block_done, pending_mask
);
  import mcdma_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  mcdma_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_ready, .q_item
  );

  mcdma_engine #(.NUM_CHANNELS(NUM_CHANNELS)) u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule
